FILE: sv/dq_pkg.sv
// Shared types and codes for the circular deque.
package dq_pkg;

    // Width of the capacity register and of the occupancy result
    localparam int CFG_W = 5;
    localparam int OCC_W = 5;

    // Capacity after reset, clamped to the storage depth at the top level
    localparam int CAP_RESET = 16;

    // Operation selector
    localparam logic [1:0] FUNC_INS_FRONT = 2'd0;
    localparam logic [1:0] FUNC_INS_REAR  = 2'd1;
    localparam logic [1:0] FUNC_REM_FRONT = 2'd2;
    localparam logic [1:0] FUNC_REM_REAR  = 2'd3;

    // Result status
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Result fields known at the time an operation is taken
    typedef struct packed {
        logic [1:0]       status;
        logic [OCC_W-1:0] occ;
        logic             empty;
        logic             full;
        logic             from_mem;
        logic             all_ones;
    } res_info_t;

endpackage

FILE: sv/dq_ram.sv
// Entry store: one write port, one read port, registered read data.
module dq_ram #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_WIDTH-1:0]    wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_WIDTH-1:0]    rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    // Write the entry on a transfer that stores a value
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Register the read entry ahead of the result
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/circular_deque.sv
// Circular deque top level: index and count control around the entry store.
//
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_ready    func, data_in
// out      output     out_valid/out_ready  status, data_out, occupancy, is_empty, is_full
// cfg      input      cfg_valid/cfg_ready  cfg_data (capacity_in_use)
//
// One operation per cycle while the output is not stalled; a result passes
// the read stage and then the output register, the extra stage covering the
// registered read of the entry store.
// Indices and count update at the input transfer, so a removal right after
// an insert reads the entry already written.
// Reset clears indices, count, stage valids and sets the capacity to 16 or
// DEPTH if smaller; store contents stay undefined until written. An output
// stall holds the result stage and then the input.
module circular_deque
    import dq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   func,
    input  logic signed [DATA_WIDTH-1:0] data_in,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   status,
    output logic signed [DATA_WIDTH-1:0] data_out,
    output logic [OCC_W-1:0]             occupancy,
    output logic                         is_empty,
    output logic                         is_full,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_W-1:0]             cfg_data
);

    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CMP_W   = ((IDX_W > CFG_W) ? IDX_W : CFG_W) + 1;
    localparam int CAP_RST = (DEPTH < CAP_RESET) ? DEPTH : CAP_RESET;

    logic [CFG_W-1:0] cap_reg;
    logic [IDX_W-1:0] front_reg, front_next;
    logic [IDX_W-1:0] rear_reg, rear_next;
    logic [OCC_W-1:0] cnt_reg, cnt_next;

    logic      s1_valid_reg;
    res_info_t s1_info_reg, s1_info_next;

    logic                  out_valid_reg;
    res_info_t             out_info_reg;
    logic [DATA_WIDTH-1:0] out_data_reg;

    logic                  in_xfer;
    logic                  s1_move;
    logic                  mem_we, mem_re;
    logic [IDX_W-1:0]      mem_waddr, mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    logic [IDX_W-1:0] cap_m1;
    logic [IDX_W-1:0] front_up, front_dn, rear_up, rear_dn;
    logic [CFG_W-1:0] cap_wr;

    // Handshakes
    assign s1_move   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_move;
    assign in_xfer   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // Clamp a written capacity into 1..DEPTH
    always_comb
    begin
        cap_wr = cfg_data;
        if (cfg_data == '0)
        begin
            cap_wr = CFG_W'(1);
        end
        else if (32'(cfg_data) > DEPTH)
        begin
            cap_wr = CFG_W'(DEPTH);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CFG_W'(CAP_RST);
        end
        else if (cfg_valid && cfg_ready)
        begin
            cap_reg <= cap_wr;
        end
    end

    // Step indices forward and backward, wrapping at the capacity
    assign cap_m1   = IDX_W'(cap_reg - 1'b1);
    assign front_up = ((CMP_W'(front_reg) + 1'b1) >= CMP_W'(cap_reg)) ? '0 : front_reg + 1'b1;
    assign rear_up  = ((CMP_W'(rear_reg) + 1'b1) >= CMP_W'(cap_reg)) ? '0 : rear_reg + 1'b1;
    assign front_dn = (front_reg == '0) ? cap_m1 : front_reg - 1'b1;
    assign rear_dn  = (rear_reg == '0) ? cap_m1 : rear_reg - 1'b1;

    // Decode the operation into index, count and store updates
    always_comb
    begin
        front_next   = front_reg;
        rear_next    = rear_reg;
        cnt_next     = cnt_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = '0;
        mem_raddr    = front_reg;
        s1_info_next = '0;
        s1_info_next.status = ST_DONE;

        unique case (func)
            FUNC_INS_FRONT, FUNC_INS_REAR:
            begin
                if (cnt_reg >= cap_reg)
                begin
                    s1_info_next.status = ST_FULL;
                end
                else
                begin
                    mem_we   = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == '0)
                    begin
                        front_next = '0;
                        rear_next  = '0;
                        mem_waddr  = '0;
                    end
                    else if (func == FUNC_INS_FRONT)
                    begin
                        front_next = front_dn;
                        mem_waddr  = front_dn;
                    end
                    else
                    begin
                        rear_next = rear_up;
                        mem_waddr = rear_up;
                    end
                end
            end
            FUNC_REM_FRONT, FUNC_REM_REAR:
            begin
                if (cnt_reg == '0)
                begin
                    s1_info_next.status   = ST_EMPTY;
                    s1_info_next.all_ones = 1'b1;
                end
                else
                begin
                    mem_re                = 1'b1;
                    s1_info_next.from_mem = 1'b1;
                    cnt_next              = cnt_reg - 1'b1;
                    if (func == FUNC_REM_FRONT)
                    begin
                        mem_raddr  = front_reg;
                        front_next = front_up;
                    end
                    else
                    begin
                        mem_raddr = rear_reg;
                        rear_next = rear_dn;
                    end
                    if (cnt_next == '0)
                    begin
                        front_next = '0;
                        rear_next  = '0;
                    end
                end
            end
            default:
            begin
                s1_info_next.status = ST_DONE;
            end
        endcase

        s1_info_next.occ   = cnt_next;
        s1_info_next.empty = (cnt_next == '0);
        s1_info_next.full  = (cnt_next >= cap_reg);
    end

    // Advance indices and count on an input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            rear_reg  <= '0;
            cnt_reg   <= '0;
        end
        else if (in_xfer)
        begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
            cnt_reg   <= cnt_next;
        end
    end

    dq_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (in_xfer && mem_we),
        .waddr (mem_waddr),
        .wdata (data_in),
        .re    (in_xfer && mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Hold the operation while the store read completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_info_reg <= s1_info_next;
        end
    end

    // Output register: load from the read stage, drop on a transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_info_reg <= s1_info_reg;
            if (s1_info_reg.from_mem)
            begin
                out_data_reg <= mem_rdata;
            end
            else if (s1_info_reg.all_ones)
            begin
                out_data_reg <= '1;
            end
            else
            begin
                out_data_reg <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_info_reg.status;
    assign data_out  = out_data_reg;
    assign occupancy = out_info_reg.occ;
    assign is_empty  = out_info_reg.empty;
    assign is_full   = out_info_reg.full;

    // Count never exceeds the storage depth
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= DEPTH)
        else $error("entry count above storage depth");

    // A stalled input means the read stage is occupied and blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled without a blocked result");

    // A removal from a non-empty deque reads the store and lowers the count
    a_rem_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && func[1] && cnt_reg != '0)
        |=> (s1_info_reg.from_mem && cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("removal did not read the store");

    // A refused insert leaves indices and count unchanged
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && !func[1] && cnt_reg >= cap_reg)
        |=> ($stable(cnt_reg) && $stable(front_reg) && $stable(rear_reg)))
        else $error("refused insert changed the deque");

    // Empty deque keeps both indices at zero
    a_empty_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (front_reg == '0 && rear_reg == '0))
        else $error("indices not at zero on an empty deque");

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the circular deque: random traffic against a deque predictor.
`timescale 1ns / 1ps

module tb_top
    import dq_pkg::*;
();

    localparam int DEPTH        = 16;
    localparam int DATA_WIDTH   = 32;
    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_AT      = 100;
    localparam int HOLD_LEN     = 60;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] value;
    } deque_op_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] value;
        logic [OCC_W-1:0]   occ;
        logic               empty;
        logic               full;
    } deque_result_t;

    // DUT ports
    logic                         clk;
    logic                         rst_n     = 1'b0;
    logic                         in_valid  = 1'b0;
    logic                         in_ready;
    logic [1:0]                   func      = FUNC_INS_REAR;
    logic signed [DATA_WIDTH-1:0] data_in   = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [1:0]                   status;
    logic signed [DATA_WIDTH-1:0] data_out;
    logic [OCC_W-1:0]             occupancy;
    logic                         is_empty;
    logic                         is_full;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [CFG_W-1:0]             cfg_data  = '0;

    // Traffic bookkeeping
    deque_op_t     op_queue[$];
    deque_result_t awaited_results[$];
    logic          in_taken   = 1'b0;
    logic          out_taken  = 1'b0;
    logic          no_idle    = 1'b0;
    logic          hold_done  = 1'b0;
    int            hold_left  = 0;
    int            send_gap   = 0;
    int            rx_wait    = 0;
    int            results_seen = 0;
    int            error_count  = 0;
    int            cfg_writes   = 0;
    int            cycle_count  = 0;
    int            op_tally[4] = '{0, 0, 0, 0};

    // Predicted deque contents
    logic signed [31:0] entries [DEPTH];
    logic [3:0]         front_idx  = '0;
    logic [3:0]         rear_idx   = '0;
    logic [OCC_W-1:0]   held_count = '0;
    logic [CFG_W-1:0]   cap_now    = CFG_W'(CAP_RESET);

    circular_deque #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .data_in   (data_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .data_out  (data_out),
        .occupancy (occupancy),
        .is_empty  (is_empty),
        .is_full   (is_full),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Step an index forward or back, wrapping at the capacity in use
    function automatic logic [3:0] ring_next(input logic [3:0] idx);
        return (int'(idx) + 1 >= int'(cap_now)) ? 4'd0 : idx + 4'd1;
    endfunction

    function automatic logic [3:0] ring_prev(input logic [3:0] idx);
        return (idx == 4'd0) ? 4'(cap_now - 1'b1) : idx - 4'd1;
    endfunction

    function automatic logic [CFG_W-1:0] clamp_capacity(input logic [CFG_W-1:0] value);
        if (value == 0)
            return CFG_W'(1);
        if (int'(value) > DEPTH)
            return CFG_W'(DEPTH);
        return value;
    endfunction

    // Apply one operation to the predicted deque and queue its result
    task automatic apply_deque_op(input logic [1:0] op, input logic signed [31:0] value);
        deque_result_t r;
        logic [3:0]    slot;
        r = '0;
        r.status = ST_DONE;
        op_tally[op]++;
        if (op == FUNC_INS_FRONT || op == FUNC_INS_REAR)
        begin
            if (held_count >= cap_now)
                r.status = ST_FULL;
            else
            begin
                if (held_count == 0)
                begin
                    front_idx = '0;
                    rear_idx  = '0;
                    slot      = '0;
                end
                else if (op == FUNC_INS_FRONT)
                begin
                    front_idx = ring_prev(front_idx);
                    slot      = front_idx;
                end
                else
                begin
                    rear_idx = ring_next(rear_idx);
                    slot     = rear_idx;
                end
                entries[slot] = value;
                held_count++;
            end
        end
        else if (held_count == 0)
        begin
            r.status = ST_EMPTY;
            r.value  = -1;
        end
        else
        begin
            if (op == FUNC_REM_FRONT)
            begin
                r.value   = entries[front_idx];
                front_idx = ring_next(front_idx);
            end
            else
            begin
                r.value  = entries[rear_idx];
                rear_idx = ring_prev(rear_idx);
            end
            held_count--;
            if (held_count == 0)
            begin
                front_idx = '0;
                rear_idx  = '0;
            end
        end
        r.occ   = held_count;
        r.empty = (held_count == 0);
        r.full  = (held_count >= cap_now);
        awaited_results.push_back(r);
    endtask

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= REPORT_MAX)
            $display("ERROR: %s", msg);
    endtask

    function automatic void queue_op(input logic [1:0] op, input logic [31:0] value);
        deque_op_t item;
        item.op    = op;
        item.value = value;
        op_queue.push_back(item);
    endfunction

    // Random traffic in stretches that lean toward filling, churning or draining
    task automatic queue_random_ops(input int count);
        int          k;
        int          stretch;
        int          ins_pct;
        logic [1:0]  op;
        logic [31:0] value;
        stretch = 0;
        ins_pct = 50;
        for (k = 0; k < count; k++)
        begin
            if (stretch == 0)
            begin
                stretch = $urandom_range(4, 24);
                case ($urandom_range(0, 2))
                    0:       ins_pct = 80;
                    1:       ins_pct = 50;
                    default: ins_pct = 20;
                endcase
            end
            stretch--;
            if ($urandom_range(0, 99) < ins_pct)
                op = $urandom_range(0, 1) ? FUNC_INS_REAR : FUNC_INS_FRONT;
            else
                op = $urandom_range(0, 1) ? FUNC_REM_REAR : FUNC_REM_FRONT;
            case ($urandom_range(0, 7))
                0:       value = 32'h7FFF_FFFF;
                1:       value = 32'h8000_0000;
                2:       value = 32'h0000_0000;
                3:       value = 32'hFFFF_FFFF;
                default: value = $urandom;
            endcase
            queue_op(op, value);
        end
    endtask

    task automatic wait_idle();
        while (op_queue.size() != 0 || in_valid || awaited_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cap_now = clamp_capacity(value);
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drain the deque, refill a run from entry zero, then change the capacity.
    // Keeping the held entries contiguous from zero means no removal ever
    // lands on an entry that was never written.
    task automatic change_capacity(input logic [CFG_W-1:0] value, input int keep);
        int n;
        wait_idle();
        n = held_count;
        repeat (n) queue_op(FUNC_REM_FRONT, $urandom);
        repeat (keep) queue_op(FUNC_INS_REAR, $urandom);
        wait_idle();
        write_capacity(value);
    endtask

    // Record input transfers and predict their results
    always @(posedge clk or negedge rst_n)
    begin : op_accept
        if (!rst_n)
        begin
            in_taken   <= 1'b0;
            held_count = '0;
            front_idx  = '0;
            rear_idx   = '0;
            cap_now    = CFG_W'(CAP_RESET);
        end
        else
        begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
                apply_deque_op(func, data_in);
        end
    end

    // Present queued operations, with a random gap after each unless no_idle is set
    always @(negedge clk)
    begin : op_driver
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else if (!in_valid || in_taken)
        begin
            if (in_taken)
                void'(op_queue.pop_front());
            if (send_gap != 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (op_queue.size() != 0)
            begin
                func     <= op_queue[0].op;
                data_in  <= op_queue[0].value;
                in_valid <= 1'b1;
                send_gap = no_idle ? 0 : $urandom_range(0, 5);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        deque_result_t want;
        if (!rst_n)
            out_taken <= 1'b0;
        else
        begin
            out_taken <= out_valid && out_ready;
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (awaited_results.size() == 0)
                    report_error($sformatf("result %0d with none pending: status %0d data %0d",
                                           results_seen, status, data_out));
                else
                begin
                    want = awaited_results.pop_front();
                    if (status !== want.status)
                        report_error($sformatf("result %0d status: expected %0d, got %0d",
                                               results_seen, want.status, status));
                    if (data_out !== want.value)
                        report_error($sformatf("result %0d data_out: expected %0d, got %0d",
                                               results_seen, want.value, data_out));
                    if (occupancy !== want.occ)
                        report_error($sformatf("result %0d occupancy: expected %0d, got %0d",
                                               results_seen, want.occ, occupancy));
                    if (is_empty !== want.empty)
                        report_error($sformatf("result %0d is_empty: expected %0b, got %0b",
                                               results_seen, want.empty, is_empty));
                    if (is_full !== want.full)
                        report_error($sformatf("result %0d is_full: expected %0b, got %0b",
                                               results_seen, want.full, is_full));
                end
            end
        end
    end

    // Hold off the receiver once for a long stretch so the block backs up
    always @(negedge clk)
    begin : rx_holdoff
        if (!rst_n)
            hold_left <= 0;
        else if (!hold_done && results_seen >= HOLD_AT)
        begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Stall the result side for a random count after each transfer
    always @(negedge clk)
    begin : rx_driver
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_wait = 0;
        end
        else
        begin
            if (out_taken)
                rx_wait = no_idle ? 0 : $urandom_range(0, 5);
            if (hold_left != 0)
                out_ready <= 1'b0;
            else if (rx_wait != 0)
            begin
                rx_wait--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Bound the run
    always @(posedge clk)
    begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin : stimulus
        int w;
        int leftover;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty refusals, wrap of the front below entry zero, signed extremes
        queue_op(FUNC_REM_FRONT, 32'h1234_5678);
        queue_op(FUNC_REM_REAR, 32'hFFFF_FFFF);
        queue_op(FUNC_INS_FRONT, 32'h7FFF_FFFF);
        queue_op(FUNC_INS_REAR, 32'h8000_0000);
        queue_op(FUNC_INS_FRONT, 32'hFFFF_FFFF);
        queue_op(FUNC_INS_REAR, 32'h0000_0000);
        queue_op(FUNC_REM_FRONT, 32'h0000_0000);
        queue_op(FUNC_REM_REAR, 32'hFFFF_FFFF);
        queue_op(FUNC_REM_FRONT, 32'h5555_5555);
        queue_op(FUNC_REM_REAR, 32'hAAAA_AAAA);
        queue_op(FUNC_REM_REAR, 32'h0000_0000);

        // Small capacity: full refusals on both ends and wrap of the front both ways
        change_capacity(5'd2, 0);
        queue_op(FUNC_INS_REAR, 32'hAAAA_AAAA);
        queue_op(FUNC_INS_FRONT, 32'h5555_5555);
        queue_op(FUNC_INS_FRONT, 32'h0F0F_0F0F);
        queue_op(FUNC_INS_REAR, 32'hF0F0_F0F0);
        queue_op(FUNC_REM_FRONT, 32'h0000_0000);
        queue_op(FUNC_INS_REAR, 32'h1357_9BDF);
        queue_op(FUNC_REM_REAR, 32'h0000_0000);
        queue_op(FUNC_REM_REAR, 32'h0000_0000);
        queue_op(FUNC_REM_FRONT, 32'h0000_0000);

        // Random phases over a range of capacities, some of them changed
        // while entries are held
        change_capacity(5'd16, 0);
        queue_random_ops(200);
        change_capacity(5'd0, 0);
        no_idle = 1'b1;
        queue_random_ops(40);
        change_capacity(5'd5, 0);
        no_idle = 1'b0;
        queue_random_ops(60);
        change_capacity(5'd31, 3);
        queue_random_ops(100);
        change_capacity(5'd4, 10);
        queue_random_ops(80);
        change_capacity(5'd17, 2);
        no_idle = 1'b1;
        queue_random_ops(100);
        change_capacity(5'd9, 0);
        no_idle = 1'b0;
        queue_random_ops(70);

        // Let everything drain, then watch for stray results
        while (op_queue.size() != 0 || in_valid)
            @(posedge clk);
        for (w = 0; w < 2000 && awaited_results.size() != 0; w++)
            @(posedge clk);
        repeat (20) @(posedge clk);
        leftover = awaited_results.size();
        if (leftover != 0)
            report_error($sformatf("%0d predicted results never arrived", leftover));

        $display("Run covered %0d operations (%0d/%0d front/rear inserts, %0d/%0d %s)",
                 op_tally[FUNC_INS_FRONT] + op_tally[FUNC_INS_REAR] +
                 op_tally[FUNC_REM_FRONT] + op_tally[FUNC_REM_REAR],
                 op_tally[FUNC_INS_FRONT], op_tally[FUNC_INS_REAR],
                 op_tally[FUNC_REM_FRONT], op_tally[FUNC_REM_REAR],
                 "front/rear removals");
        $display("%0d results checked across %0d capacity writes, %0d errors",
                 results_seen, cfg_writes, error_count);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: circular_deque.f
sv/dq_pkg.sv
sv/dq_ram.sv
sv/circular_deque.sv
test/tb_top.sv
